FILE: sv/lcsafs_pkg.sv
// Shared types and constants for the pattern-avoiding common subsequence block.
package lcsafs_pkg;

  localparam int SYM_W = 5;
  localparam int OP_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_APPEND_PAT    = 2'd2,
    OP_RUN           = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAT,
    S_ROW_RD,
    S_ROW_WR,
    S_ZROW,
    S_CLR,
    S_RA,
    S_RB,
    S_C0,
    S_C1,
    S_C2,
    S_C3,
    S_OUT
  } state_t;

endpackage

FILE: sv/lcsafs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lcsafs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/lcs_avoiding_forbidden_substring.sv
// Top level: longest common subsequence of two strings that avoids a pattern.
//
// Input channel (in_valid/in_ready, opcode, symbol): opcodes 0, 1 and 2 append
// a letter to the first string, the second string or the pattern; a letter
// outside the alphabet or an append to a full store is dropped. Appends go in
// back to back and give no result. Opcode 3 starts a run, which yields one
// result on the output channel (out_valid/out_ready, best_length, found).
// n, m, p are the loaded lengths. After the run transaction the block builds
// the goto table (per row a pattern fetch, then a read and a write step per
// letter; then a zero row for the full-match state), clears both score layers
// of (m+1)*(p+1) words each, then runs the DP sweep over n+1 rows: a step per
// row and per (row, column) pair to fetch letters, then the cell steps C0, C1,
// C2 and a C3 step when a match move is taken. The result is offered the cycle
// after the sweep. in_ready is low from the run until the result transaction
// completes; a stalled receiver holds the block there.
// Reset empties all three strings and returns the block to idle; the
// strings are kept across runs.
module lcs_avoiding_forbidden_substring
  import lcsafs_pkg::*;
#(
  parameter int MAX_TEXT    = 128,
  parameter int MAX_PATTERN = 128,
  parameter int ALPHABET    = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  opcode,
  input  logic [SYM_W-1:0] symbol,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       best_length,
  output logic             found
);

  localparam int JW   = $clog2(MAX_TEXT + 1);
  localparam int KW   = $clog2(MAX_PATTERN + 1);
  localparam int TAW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int PAW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int GAW  = KW + SYM_W;
  localparam int SAW  = 1 + JW + KW;
  localparam int SW   = 2 * JW;

  state_t state, state_next;

  logic [JW-1:0]    first_len, second_len;
  logic [KW-1:0]    pat_len;
  logic [JW-1:0]    i, j;
  logic [KW-1:0]    k;
  logic [SYM_W-1:0] c;
  logic             layer;
  logic [KW-1:0]    fail_k, fail_nxt;
  logic [JW-1:0]    best;
  logic [JW-1:0]    v;
  logic             v_ok;
  logic [KW-1:0]    nk;

  // RAM ports
  logic             a_we, b_we, p_we, a_re, b_re, p_re;
  logic [SYM_W-1:0] a_rd, b_rd, p_rd;
  logic             g_we, g_re;
  logic [GAW-1:0]   g_waddr, g_raddr;
  logic [KW-1:0]    g_wdata, g_rd;
  logic             s_we, s_re;
  logic [SAW-1:0]   s_waddr, s_raddr;
  logic [SW-1:0]    s_wdata, s_rd;
  logic             l_we, l_re;
  logic [JW:0]      l_wdata, l_rd;

  logic accept_in, sym_ok;
  logic last_c, last_k, last_j, last_i;
  logic cur_ok, left_ok, v_ok_c, diag_ok, match_c;
  logic [JW-1:0] cur_val, v_c, i_inc, merged_skip, v_inc, merged_diag;

  assign accept_in = in_valid && in_ready;
  assign sym_ok    = ({1'b0, symbol} < (SYM_W+1)'(ALPHABET));
  assign last_c    = (c == SYM_W'(ALPHABET - 1));
  assign last_k    = (k == pat_len);
  assign last_j    = (j == second_len);
  assign last_i    = (i == first_len);
  assign i_inc     = i + JW'(1);
  assign v_inc     = v + JW'(1);

  // Cell value: pushes from the row above and diagonal, merged with the left push
  assign cur_ok  = (i == '0) ? (j == '0 && k == '0) : (s_rd[SW-1:JW] == i);
  assign cur_val = (i == '0) ? '0 : s_rd[JW-1:0];
  assign left_ok = (j != '0) && l_rd[JW];
  always_comb begin
    v_ok_c = cur_ok || left_ok;
    if (cur_ok && left_ok) begin
      v_c = (cur_val > l_rd[JW-1:0]) ? cur_val : l_rd[JW-1:0];
    end else if (cur_ok) begin
      v_c = cur_val;
    end else begin
      v_c = l_rd[JW-1:0];
    end
  end

  assign diag_ok     = (s_rd[SW-1:JW] == i_inc);
  assign merged_skip = (diag_ok && s_rd[JW-1:0] > v) ? s_rd[JW-1:0] : v;
  assign merged_diag = (diag_ok && s_rd[JW-1:0] > v_inc) ? s_rd[JW-1:0] : v_inc;
  assign match_c     = v_ok && !last_i && !last_j && (a_rd == b_rd)
                       && !(pat_len != '0 && nk == pat_len);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_in && opcode == OP_RUN) begin
          state_next = (pat_len == '0) ? S_ZROW : S_PAT;
        end
      end
      S_PAT:    state_next = S_ROW_RD;
      S_ROW_RD: state_next = S_ROW_WR;
      S_ROW_WR: begin
        if (!last_c) begin
          state_next = S_ROW_RD;
        end else if (k + KW'(1) < pat_len) begin
          state_next = S_PAT;
        end else begin
          state_next = S_ZROW;
        end
      end
      S_ZROW:   state_next = last_c ? S_CLR : S_ZROW;
      S_CLR:    state_next = (layer && last_j && last_k) ? S_RA : S_CLR;
      S_RA:     state_next = S_RB;
      S_RB:     state_next = S_C0;
      S_C0:     state_next = S_C1;
      S_C1:     state_next = S_C2;
      S_C2, S_C3: begin
        if (state == S_C2 && match_c) begin
          state_next = S_C3;
        end else if (!last_k) begin
          state_next = S_C0;
        end else if (!last_j) begin
          state_next = S_RB;
        end else if (!last_i) begin
          state_next = S_RA;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT:    state_next = out_ready ? S_IDLE : S_OUT;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory controls and handshake outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    a_we = 1'b0; b_we = 1'b0; p_we = 1'b0;
    a_re = 1'b0; b_re = 1'b0; p_re = 1'b0;
    g_we = 1'b0; g_re = 1'b0; g_waddr = {k, c}; g_raddr = {fail_k, c}; g_wdata = '0;
    s_we = 1'b0; s_re = 1'b0; s_waddr = {layer, j, k}; s_raddr = {i[0], j, k};
    s_wdata = '0;
    l_we = 1'b0; l_re = 1'b0; l_wdata = {v_ok_c, v_c};
    case (state)
      S_IDLE: begin
        if (accept_in && sym_ok) begin
          a_we = (opcode == OP_APPEND_FIRST)  && (first_len  < JW'(MAX_TEXT));
          b_we = (opcode == OP_APPEND_SECOND) && (second_len < JW'(MAX_TEXT));
          p_we = (opcode == OP_APPEND_PAT)    && (pat_len    < KW'(MAX_PATTERN));
        end
      end
      S_PAT:    p_re = 1'b1;
      S_ROW_RD: g_re = (k != '0);
      S_ROW_WR: begin
        g_we = 1'b1;
        if (p_rd == c) begin
          g_wdata = k + KW'(1);
        end else begin
          g_wdata = (k == '0) ? '0 : g_rd;
        end
      end
      S_ZROW: begin
        g_we    = 1'b1;
        g_waddr = {pat_len, c};
      end
      S_CLR:  s_we = 1'b1;
      S_RA:   a_re = 1'b1;
      S_RB:   b_re = 1'b1;
      S_C0: begin
        s_re    = 1'b1;
        l_re    = 1'b1;
        g_re    = 1'b1;
        g_raddr = {k, a_rd};
      end
      S_C1: begin
        l_we    = 1'b1;
        s_re    = 1'b1;
        s_raddr = {~i[0], j, k};
      end
      S_C2: begin
        s_we    = v_ok && !last_i;
        s_waddr = {~i[0], j, k};
        s_wdata = {i_inc, merged_skip};
        s_re    = match_c;
        s_raddr = {~i[0], j + JW'(1), nk};
      end
      S_C3: begin
        s_we    = 1'b1;
        s_waddr = {~i[0], j + JW'(1), nk};
        s_wdata = {i_inc, merged_diag};
      end
      default: begin
      end
    endcase
  end

  // Counters, lengths and per-cell registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= '0;
      second_len <= '0;
      pat_len    <= '0;
      i <= '0; j <= '0; k <= '0; c <= '0; layer <= 1'b0;
      fail_k <= '0; fail_nxt <= '0;
      best <= '0;
      v_ok <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (a_we) first_len  <= first_len + JW'(1);
          if (b_we) second_len <= second_len + JW'(1);
          if (p_we) pat_len    <= pat_len + KW'(1);
          i <= '0; j <= '0; k <= '0; c <= '0; layer <= 1'b0;
          fail_k <= '0; fail_nxt <= '0; best <= '0;
        end
        S_ROW_WR: begin
          if (p_rd == c) begin
            fail_nxt <= (k == '0) ? '0 : g_rd;
          end
          if (last_c) begin
            c      <= '0;
            k      <= k + KW'(1);
            fail_k <= (p_rd == c) ? ((k == '0) ? '0 : g_rd) : fail_nxt;
          end else begin
            c <= c + SYM_W'(1);
          end
        end
        S_ZROW: begin
          c <= last_c ? '0 : c + SYM_W'(1);
          k <= '0;
        end
        S_CLR: begin
          if (!last_k) begin
            k <= k + KW'(1);
          end else begin
            k <= '0;
            if (!last_j) begin
              j <= j + JW'(1);
            end else begin
              j     <= '0;
              layer <= ~layer;
            end
          end
        end
        S_C1: begin
          v    <= v_c;
          v_ok <= v_ok_c;
          nk   <= g_rd;
          if (v_ok_c && v_c > best) best <= v_c;
        end
        S_C2, S_C3: begin
          if (!(state == S_C2 && match_c)) begin
            if (!last_k) begin
              k <= k + KW'(1);
            end else begin
              k <= '0;
              if (!last_j) begin
                j <= j + JW'(1);
              end else begin
                j <= '0;
                if (!last_i) i <= i_inc;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign best_length = 8'(best);
  assign found       = (best != '0);

  lcsafs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_TEXT)) u_first (
    .clk, .we(a_we), .waddr(first_len[TAW-1:0]), .wdata(symbol),
    .re(a_re), .raddr(i[TAW-1:0]), .rdata(a_rd)
  );

  lcsafs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_TEXT)) u_second (
    .clk, .we(b_we), .waddr(second_len[TAW-1:0]), .wdata(symbol),
    .re(b_re), .raddr(j[TAW-1:0]), .rdata(b_rd)
  );

  lcsafs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_PATTERN)) u_pattern (
    .clk, .we(p_we), .waddr(pat_len[PAW-1:0]), .wdata(symbol),
    .re(p_re), .raddr(k[PAW-1:0]), .rdata(p_rd)
  );

  lcsafs_ram #(.WIDTH(KW), .DEPTH(1 << GAW)) u_goto (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(g_re), .raddr(g_raddr), .rdata(g_rd)
  );

  // Score words carry the target row as a tag; a stale tag reads as unreachable
  lcsafs_ram #(.WIDTH(SW), .DEPTH(1 << SAW)) u_score (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rd)
  );

  lcsafs_ram #(.WIDTH(JW + 1), .DEPTH(MAX_PATTERN + 1)) u_left (
    .clk, .we(l_we), .waddr(k), .wdata(l_wdata),
    .re(l_re), .raddr(k), .rdata(l_rd)
  );

  a_no_input_during_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_diag_after_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_C3) |-> $past(state == S_C2))
    else $error("diagonal update without a preceding cell step");

  a_state_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_C0 || state == S_C1 || state == S_C2) |-> (k <= pat_len))
    else $error("automaton state beyond pattern length");

  a_found_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (best_length != 8'd0)))
    else $error("found flag disagrees with length");

endmodule

FILE: verif/lcs_avoiding_forbidden_substring_test.sv
// Testbench for the pattern-avoiding common subsequence block.
`timescale 1ns / 100ps

module lcs_avoiding_forbidden_substring_test
  import lcsafs_pkg::*;
;

  localparam int TEXT_MAX  = 128;
  localparam int PAT_MAX   = 128;
  localparam int LETTERS   = 26;
  localparam int RANDOM_N  = 1150;
  localparam int IDLE_MAX  = 1500000;
  localparam int TAIL_WAIT = 50;

  typedef struct {
    op_t        op;
    logic [4:0] sym;
    bit         drain;
  } load_item_t;

  typedef struct {
    logic [7:0] length;
    logic       found;
  } lcs_result_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  opcode;
  logic [SYM_W-1:0] symbol;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       best_length;
  logic             found;

  lcs_avoiding_forbidden_substring dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .symbol(symbol),
    .out_valid(out_valid), .out_ready(out_ready),
    .best_length(best_length), .found(found)
  );

  load_item_t  pending_items[$];
  lcs_result_t expected_lengths[$];

  // predictor copy of the block's stores
  int text_a[TEXT_MAX];
  int text_b[TEXT_MAX];
  int pat[PAT_MAX];
  int len_a, len_b, len_p;
  int goto_next[PAT_MAX+1][LETTERS];
  int fail_link[PAT_MAX+1];
  bit unsafe[PAT_MAX+1];
  int layer[2][TEXT_MAX+1][PAT_MAX+1];

  int errors, runs_done, appends_done, results_seen, idle_cycles;
  int in_hold, out_hold;
  bit steady;

  function automatic int longest_safe_lcs();
    int f, pc, cur, nxt, v, nk, best, states;
    best = 0;
    states = len_p + 1;
    for (int k = 0; k <= PAT_MAX; k++) begin
      fail_link[k] = 0;
      unsafe[k] = 0;
      for (int c = 0; c < LETTERS; c++) goto_next[k][c] = 0;
    end
    if (len_p > 0) begin
      for (int c = 0; c < LETTERS; c++) goto_next[0][c] = (pat[0] == c) ? 1 : 0;
      for (int k = 1; k < len_p; k++) begin
        f = fail_link[k];
        pc = pat[k];
        for (int c = 0; c < LETTERS; c++)
          goto_next[k][c] = (pc == c) ? k + 1 : goto_next[f][c];
        fail_link[k+1] = goto_next[f][pc];
      end
      for (int k = 0; k <= len_p; k++)
        unsafe[k] = (k == len_p) || (k > 0 && unsafe[fail_link[k]]);
    end
    for (int j = 0; j <= len_b; j++)
      for (int k = 0; k < states; k++) layer[0][j][k] = -1;
    layer[0][0][0] = 0;
    for (int i = 0; i <= len_a; i++) begin
      cur = i & 1;
      nxt = cur ^ 1;
      if (i < len_a)
        for (int j = 0; j <= len_b; j++)
          for (int k = 0; k < states; k++) layer[nxt][j][k] = -1;
      for (int j = 0; j <= len_b; j++) begin
        for (int k = 0; k < states; k++) begin
          v = layer[cur][j][k];
          if (v >= 0) begin
            if (v > best) best = v;
            if (i < len_a && layer[nxt][j][k] < v) layer[nxt][j][k] = v;
            if (j < len_b && layer[cur][j+1][k] < v) layer[cur][j+1][k] = v;
            if (i < len_a && j < len_b && text_a[i] == text_b[j]) begin
              nk = goto_next[k][text_a[i]];
              if (nk < states && !unsafe[nk] && layer[nxt][j+1][nk] < v + 1)
                layer[nxt][j+1][nk] = v + 1;
            end
          end
        end
      end
    end
    return best;
  endfunction

  task automatic apply_item(input op_t op, input logic [4:0] sym);
    lcs_result_t r;
    int best;
    if (op == OP_RUN) begin
      best = longest_safe_lcs();
      r.length = best[7:0];
      r.found = (best > 0);
      expected_lengths.push_back(r);
      runs_done++;
    end else if (sym < LETTERS) begin
      appends_done++;
      case (op)
        OP_APPEND_FIRST:  if (len_a < TEXT_MAX) begin text_a[len_a] = sym; len_a++; end
        OP_APPEND_SECOND: if (len_b < TEXT_MAX) begin text_b[len_b] = sym; len_b++; end
        default:          if (len_p < PAT_MAX) begin pat[len_p] = sym; len_p++; end
      endcase
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_item(input op_t op, input int sym);
    load_item_t it;
    it.op = op;
    it.sym = sym[4:0];
    it.drain = 0;
    pending_items.push_back(it);
  endtask

  task automatic queue_drain();
    load_item_t it;
    it.op = OP_RUN;
    it.sym = '0;
    it.drain = 1;
    pending_items.push_back(it);
  endtask

  function automatic int pick_letter();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(0, LETTERS - 1);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      opcode <= '0;
      symbol <= '0;
      in_hold <= 0;
    end else begin
      if (in_valid && in_ready) apply_item(op_t'(opcode), symbol);
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_hold <= in_hold - 1;
          in_valid <= 0;
        end else if (pending_items.size() > 0 && pending_items[0].drain) begin
          in_valid <= 0;
          if (expected_lengths.size() == 0) void'(pending_items.pop_front());
        end else if (pending_items.size() > 0) begin
          opcode <= pending_items[0].op;
          symbol <= pending_items[0].sym;
          void'(pending_items.pop_front());
          in_valid <= 1;
          in_hold <= pick_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      out_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_lengths.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: best_length=%0d found=%0b",
                                     best_length, found);
        end else begin
          if (best_length !== expected_lengths[0].length ||
              found !== expected_lengths[0].found) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected best_length=%0d found=%0b, got %0d %0b",
                       expected_lengths[0].length, expected_lengths[0].found,
                       best_length, found);
          end
          void'(expected_lengths.pop_front());
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        out_hold <= pick_gap();
      end
      if ($urandom_range(0, 299) == 0) steady <= ~steady;
    end
  end

  // watchdog: give up when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int cap_a, cap_b, cap_p, gen_a, gen_b, gen_p, r, o;
    rst = 1;
    in_valid = 0;
    opcode = '0;
    symbol = '0;
    out_ready = 0;
    steady = 0;
    errors = 0;
    runs_done = 0;
    appends_done = 0;
    results_seen = 0;
    len_a = 0;
    len_b = 0;
    len_p = 0;
    for (int i = 0; i < TEXT_MAX; i++) begin text_a[i] = 0; text_b[i] = 0; pat[i] = 0; end

    // directed: empty strings, plain LCS, dropped letters, extremes, forbidden letter
    queue_item(OP_RUN, 0);
    queue_item(OP_APPEND_FIRST, 0);
    queue_item(OP_RUN, 31);
    queue_item(OP_APPEND_SECOND, 0);
    queue_item(OP_RUN, 0);
    queue_item(OP_APPEND_PAT, 31);
    queue_item(OP_APPEND_FIRST, 26);
    queue_item(OP_APPEND_SECOND, 30);
    queue_item(OP_APPEND_FIRST, 25);
    queue_item(OP_APPEND_SECOND, 25);
    queue_item(OP_RUN, 0);
    queue_item(OP_APPEND_PAT, 25);
    queue_item(OP_RUN, 0);
    queue_item(OP_APPEND_FIRST, 1);
    queue_item(OP_APPEND_SECOND, 1);
    queue_item(OP_APPEND_PAT, 1);
    queue_item(OP_RUN, 0);
    queue_drain();
    gen_a = 3;
    gen_b = 3;
    gen_p = 2;

    // random: strings persist, so let them grow slowly across the run
    for (int idx = 0; idx < RANDOM_N; idx++) begin
      cap_a = 3 + idx / 150;
      cap_b = 3 + idx / 250;
      cap_p = 2 + idx / 500;
      r = $urandom_range(0, 99);
      o = $urandom_range(0, 2);
      if (idx % 200 == 199) queue_drain();
      if (r < 10) begin
        queue_item(op_t'(o), $urandom_range(LETTERS, 31));
      end else if (r < 30) begin
        queue_item(OP_RUN, $urandom_range(0, 31));
      end else if (o == 0 && gen_a < cap_a) begin
        queue_item(OP_APPEND_FIRST, pick_letter());
        gen_a++;
      end else if (o == 1 && gen_b < cap_b) begin
        queue_item(OP_APPEND_SECOND, pick_letter());
        gen_b++;
      end else if (o == 2 && gen_p < cap_p) begin
        queue_item(OP_APPEND_PAT, pick_letter());
        gen_p++;
      end else begin
        queue_item(op_t'(o), $urandom_range(LETTERS, 31));
      end
    end

    // fill both strings past capacity; extra letters must be dropped
    queue_drain();
    for (int i = gen_a; i < TEXT_MAX + 2; i++) queue_item(OP_APPEND_FIRST, pick_letter());
    queue_item(OP_RUN, 0);
    for (int i = gen_b; i < TEXT_MAX + 2; i++) queue_item(OP_APPEND_SECOND, pick_letter());
    queue_item(OP_RUN, 0);

    repeat (4) @(posedge clk);
    rst <= 0;

    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_lengths.size() > 0);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d runs and %0d letter appends, %0d results checked",
             runs_done, appends_done, results_seen);
    $display("final lengths: first %0d, second %0d, pattern %0d", len_a, len_b, len_p);
    if (errors == 0 && expected_lengths.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
